// ===== design/tofe_pkg.sv =====
// Shared types and character constants for the two-operand formula evaluator.
`default_nettype none

package tofe_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADOP    = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // control half of a command handed from the parser to the execute side
  typedef struct packed {
    op_t     op;
    status_t status;
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // output request layout
  localparam int RES_W  = 32;
  localparam int OPND_W = 31;
  localparam int TDATA_W = 96;
  localparam int TUSER_W = 3;

endpackage

`default_nettype wire

// ===== design/tofe_front.sv =====
// Character parser: accumulates operands and issues one command per formula.
`default_nettype none

module tofe_front
  import tofe_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,
  input  wire logic                   q_full,
  output logic                        push,
  output cmd_ctl_t                    push_ctl,
  output logic [VALUE_WIDTH-2:0]      push_a,
  output logic [VALUE_WIDTH-2:0]      push_b
);

  localparam int OW = VALUE_WIDTH - 1;

  logic          phase;
  logic [OW-1:0] first_value;
  logic [OW-1:0] second_value;
  op_t           op_held;
  logic          overflow_seen;

  logic          accept;
  logic          digit;
  logic [7:0]    char_off;
  logic [3:0]    dig;
  logic [OW-1:0] acc;
  logic [OW+3:0] acc_x10;
  logic          sat;
  logic [OW-1:0] acc_next;
  logic          is_op;
  op_t           op_dec;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    digit    = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    char_off = s_tdata - CH_ZERO;
    dig      = char_off[3:0];
    acc      = phase ? second_value : first_value;
    // acc*10 + d, checked against the saturation limit in the wide form
    acc_x10  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{OW{1'b0}}, dig};
    sat      = acc_x10 > {4'b0, {OW{1'b1}}};
    acc_next = sat ? {OW{1'b1}} : acc_x10[OW-1:0];
    is_op    = 1'b1;
    unique case (s_tdata)
      CH_PLUS:  op_dec = OP_ADD;
      CH_MINUS: op_dec = OP_SUB;
      CH_STAR:  op_dec = OP_MUL;
      CH_SLASH: op_dec = OP_DIV;
      default: begin
        op_dec = OP_ADD;
        is_op  = 1'b0;
      end
    endcase
  end

  always_comb begin
    push            = 1'b0;
    push_a          = first_value;
    push_b          = second_value;
    push_ctl.op     = op_held;
    push_ctl.status = overflow_seen ? ST_OVERFLOW : ST_OK;
    if (accept && !digit) begin
      if (!phase) begin
        if (!is_op) begin
          push            = 1'b1;
          push_b          = '0;
          push_ctl.op     = OP_ADD;
          push_ctl.status = ST_BADOP;
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase         <= 1'b0;
      first_value   <= '0;
      second_value  <= '0;
      op_held       <= OP_ADD;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (digit) begin
        if (phase) second_value <= acc_next;
        else       first_value  <= acc_next;
        if (sat) overflow_seen <= 1'b1;
      end else if (!phase) begin
        op_held <= op_dec;
        phase   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tofe_queue.sv =====
// Two-entry command queue between parser and execute unit.
`default_nettype none

module tofe_queue #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data,
  output logic                  full
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign head_valid = count != 2'd0;
  assign full       = count == 2'd2;
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== design/tofe_back.sv =====
// Execute unit: add/subtract directly, multiply/divide on a shared shift unit.
`default_nettype none

module tofe_back
  import tofe_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire cmd_ctl_t               q_ctl,
  input  wire logic [VALUE_WIDTH-2:0] q_a,
  input  wire logic [VALUE_WIDTH-2:0] q_b,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [VALUE_WIDTH-1:0]      out_result,
  output logic [VALUE_WIDTH-2:0]      out_left,
  output logic [VALUE_WIDTH-2:0]      out_right,
  output op_t                         out_op,
  output status_t                     out_status,
  output logic                        out_wrap
);

  localparam int OW  = VALUE_WIDTH - 1;
  localparam int CNW = $clog2(OW + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t         state;
  state_t         state_next;
  cmd_ctl_t       ctl;
  logic [OW-1:0]  a;
  logic [OW-1:0]  b;
  logic [OW-1:0]  hi;
  logic [OW-1:0]  lo;
  logic [OW-1:0]  hi_next;
  logic [OW-1:0]  lo_next;
  logic [CNW-1:0] cnt;

  logic              out_free;
  logic              load_out;
  logic [OW:0]       mul_sum;
  logic [OW:0]       div_trial;
  logic [OW:0]       div_diff;
  logic [OW:0]       addsub;
  logic [OW:0]       res;
  status_t           st;
  logic              wr;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_HOLD) && out_free;

  always_comb begin
    // multiply: conditional add into the high half, then shift right
    mul_sum   = {1'b0, hi} + (lo[0] ? {1'b0, a} : '0);
    // divide: restoring step, remainder in hi, dividend/quotient in lo
    div_trial = {hi, lo[OW-1]};
    div_diff  = div_trial - {1'b0, b};
    hi_next   = hi;
    lo_next   = lo;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          hi_next = '0;
          if (q_ctl.status == ST_BADOP) begin
            state_next = S_HOLD;
          end else begin
            unique case (q_ctl.op)
              OP_MUL: begin
                lo_next    = q_b;
                state_next = S_MUL;
              end
              OP_DIV: begin
                lo_next    = q_a;
                state_next = (q_b == '0) ? S_HOLD : S_DIV;
              end
              default: state_next = S_HOLD;
            endcase
          end
        end
      end
      S_MUL: begin
        hi_next = mul_sum[OW:1];
        lo_next = {mul_sum[0], lo[OW-1:1]};
        if (cnt == CNW'(1)) state_next = S_HOLD;
      end
      S_DIV: begin
        if (!div_diff[OW]) begin
          hi_next = div_diff[OW-1:0];
          lo_next = {lo[OW-2:0], 1'b1};
        end else begin
          hi_next = div_trial[OW-1:0];
          lo_next = {lo[OW-2:0], 1'b0};
        end
        if (cnt == CNW'(1)) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    addsub = (ctl.op == OP_SUB) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
    st     = ctl.status;
    wr     = 1'b0;
    res    = '0;
    if (ctl.status != ST_BADOP) begin
      unique case (ctl.op)
        OP_ADD: begin
          res = addsub;
          wr  = addsub[OW];
        end
        OP_SUB: res = addsub;
        OP_MUL: begin
          res = {hi[0], lo};
          wr  = |hi;
        end
        OP_DIV: begin
          if (b == '0) st = ST_DIVZERO;
          else         res = {1'b0, lo};
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hi <= hi_next;
    lo <= lo_next;
    if (pop) begin
      ctl <= q_ctl;
      a   <= q_a;
      b   <= q_b;
      cnt <= CNW'(OW);
    end else if (state == S_MUL || state == S_DIV) begin
      cnt <= cnt - CNW'(1);
    end
    if (load_out) begin
      out_result <= res;
      out_left   <= a;
      out_right  <= b;
      out_op     <= ctl.op;
      out_status <= st;
      out_wrap   <= wr;
    end
  end

endmodule

`default_nettype wire

// ===== design/two_operand_formula_evaluator.sv =====
// Top level: parser, command queue and execute unit of the formula evaluator.
// Throughput: one character per cycle; the parser stalls only while the two-entry
// command queue is full.
// Path: the terminating character is queued, then popped by the idle execute unit, which
// goes straight to its hold state for add, subtract, invalid operator and divide by zero;
// multiply and divide first run the one-bit-per-cycle shift/add/subtract unit.
// Reset (rst, synchronous): clears the parser, empties the queue, idles the unit.
`default_nettype none

module two_operand_formula_evaluator
  import tofe_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,  // char_in
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // result_value[31:0], left_operand[62:32], right_operand[93:63], operator_code[95:94]
  output logic [TDATA_W-1:0]      m_tdata,
  output logic [TUSER_W-1:0]      m_tuser   // status[1:0], result_wrapped[2]
);

  localparam int OW = VALUE_WIDTH - 1;
  localparam int QW = CTL_W + 2 * OW;

  logic          push;
  cmd_ctl_t      push_ctl;
  logic [OW-1:0] push_a;
  logic [OW-1:0] push_b;
  logic          q_full;
  logic          q_valid;
  logic [QW-1:0] q_head;
  logic          pop;
  cmd_ctl_t      q_ctl;
  logic [OW-1:0] q_a;
  logic [OW-1:0] q_b;

  logic [OW:0]   out_result;
  logic [OW-1:0] out_left;
  logic [OW-1:0] out_right;
  op_t           out_op;
  status_t       out_status;
  logic          out_wrap;

  logic [OW+RES_W:0]    res_ext;
  logic [OW+OPND_W-1:0] left_ext;
  logic [OW+OPND_W-1:0] right_ext;

  tofe_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_a   (push_a),
    .push_b   (push_b)
  );

  tofe_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_ctl, push_a, push_b}),
    .pop        (pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .full       (q_full)
  );

  assign {q_ctl, q_a, q_b} = q_head;

  tofe_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_a        (q_a),
    .q_b        (q_b),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result),
    .out_left   (out_left),
    .out_right  (out_right),
    .out_op     (out_op),
    .out_status (out_status),
    .out_wrap   (out_wrap)
  );

  // fit internal widths to the fixed request fields
  assign res_ext   = {{RES_W{1'b0}}, out_result};
  assign left_ext  = {{OPND_W{1'b0}}, out_left};
  assign right_ext = {{OPND_W{1'b0}}, out_right};

  assign m_tdata = {out_op, right_ext[OPND_W-1:0], left_ext[OPND_W-1:0], res_ext[RES_W-1:0]};
  assign m_tuser = {out_wrap, out_status};

endmodule

`default_nettype wire

// ===== design/tofe_checker.sv =====
// Port-level checks for the formula evaluator, bound to the top level.
`default_nettype none

module tofe_checker
  import tofe_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic [TUSER_W-1:0] m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result request valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result request changed");

  a_badop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ST_BADOP |->
      m_tdata[31:0] == 32'd0 && m_tdata[93:63] == 31'd0 &&
      m_tdata[95:94] == OP_ADD && !m_tuser[2])
    else $error("invalid-operator result carries data");

  a_divzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ST_DIVZERO |->
      m_tdata[95:94] == OP_DIV && m_tdata[93:63] == 31'd0 &&
      m_tdata[31:0] == 32'd0 && !m_tuser[2])
    else $error("divide-by-zero result inconsistent");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |->
      (m_tdata[95:94] == OP_ADD || m_tdata[95:94] == OP_MUL))
    else $error("wrap flagged on subtract or divide");

endmodule

bind two_operand_formula_evaluator tofe_checker u_tofe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== sim/two_operand_formula_evaluator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench: character stream in, formula results compared with a local evaluator.
module two_operand_formula_evaluator_tb;
  import tofe_pkg::*;

  localparam int VALUE_WIDTH    = 32;
  localparam logic [63:0] OPND_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] VAL_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;
  localparam int STALL_PCT      = 14;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // same bit order as {m_tdata, m_tuser}
  typedef struct packed {
    op_t               op;
    logic [OPND_W-1:0] right;
    logic [OPND_W-1:0] left;
    logic [RES_W-1:0]  value;
    logic              wrapped;
    status_t           status;
  } answer_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic [7:0]       s_tdata  = 8'h00;
  logic             m_tready = 1'b0;
  wire              s_tready;
  wire              m_tvalid;
  wire [TDATA_W-1:0] m_tdata;
  wire [TUSER_W-1:0] m_tuser;

  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;
  int chars_sent  = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  answer_t answer_q[$];
  answer_t got, want;

  // evaluator state
  bit          in_second  = 1'b0;
  logic [63:0] lhs_acc    = '0;
  logic [63:0] rhs_acc    = '0;
  op_t         pending_op = OP_ADD;
  bit          saturated  = 1'b0;

  always #1 clk = ~clk;

  two_operand_formula_evaluator #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------- evaluator ----------------

  function automatic logic [63:0] push_digit(logic [63:0] acc, logic [7:0] c);
    logic [63:0] d;
    d = 64'(c) - 64'(CH_ZERO);
    if (acc > (OPND_MAX - d) / 64'd10) begin
      saturated = 1'b1;
      return OPND_MAX;
    end
    return acc * 64'd10 + d;
  endfunction

  task automatic clear_formula();
    in_second  = 1'b0;
    lhs_acc    = '0;
    rhs_acc    = '0;
    pending_op = OP_ADD;
    saturated  = 1'b0;
  endtask

  task automatic evaluate_char(logic [7:0] c);
    bit          is_digit;
    answer_t     a;
    logic [63:0] res;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    a = '0;
    res = '0;
    if (!in_second) begin
      if (is_digit) begin
        lhs_acc = push_digit(lhs_acc, c);
        return;
      end
      case (c)
        CH_PLUS:  pending_op = OP_ADD;
        CH_MINUS: pending_op = OP_SUB;
        CH_STAR:  pending_op = OP_MUL;
        CH_SLASH: pending_op = OP_DIV;
        default: begin
          a.left   = lhs_acc[OPND_W-1:0];
          a.op     = OP_ADD;
          a.status = ST_BADOP;
          answer_q.push_back(a);
          clear_formula();
          return;
        end
      endcase
      in_second = 1'b1;
      return;
    end
    if (is_digit) begin
      rhs_acc = push_digit(rhs_acc, c);
      return;
    end
    a.left   = lhs_acc[OPND_W-1:0];
    a.right  = rhs_acc[OPND_W-1:0];
    a.op     = pending_op;
    a.status = saturated ? ST_OVERFLOW : ST_OK;
    case (pending_op)
      OP_ADD: begin
        res = lhs_acc + rhs_acc;
        a.wrapped = res > OPND_MAX;
      end
      OP_SUB: res = lhs_acc - rhs_acc;
      OP_MUL: begin
        a.wrapped = (lhs_acc != 0) && (rhs_acc > OPND_MAX / lhs_acc);
        res = lhs_acc * rhs_acc;
      end
      default: begin
        // divide by zero wins over operand overflow
        if (rhs_acc == 0) begin
          a.status = ST_DIVZERO;
          res = '0;
        end else begin
          res = lhs_acc / rhs_acc;
        end
      end
    endcase
    res = res & VAL_MASK;
    a.value = res[RES_W-1:0];
    answer_q.push_back(a);
    clear_formula();
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic send_char(logic [7:0] c);
    while (src_gaps && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    evaluate_char(c);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] random_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic send_operand();
    int              kind;
    int              len;
    longint unsigned v;
    kind = $urandom_range(99);
    v = 0;
    if (kind < 5) return;  // empty operand
    if (kind >= 88) begin
      // 11+ digits with a nonzero lead always saturates
      len = $urandom_range(14, 11);
      send_char(CH_ZERO + 8'($urandom_range(9, 1)));
      for (int i = 1; i < len; i++) send_char(CH_ZERO + 8'($urandom_range(9)));
      return;
    end
    if (kind < 10)      v = 0;
    else if (kind < 45) v = $urandom_range(99);
    else if (kind < 65) v = $urandom_range(65535);
    else if (kind < 82) v = $urandom & 32'h7FFF_FFFF;
    else                v = 64'(OPND_MAX) - $urandom_range(3);
    if ($urandom_range(19) == 0) send_char(CH_ZERO);  // leading zero
    send_text($sformatf("%0d", v));
  endtask

  task automatic send_formula();
    send_operand();
    send_char(random_operator());
    send_operand();
    send_char(random_non_digit());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  // ---------------- tests ----------------

  task automatic test_directed();
    string cases[$];
    cases = '{"12+34=", "2147483647+1;", "99999999999*2 ", "5/0\n", "-7/2", "7/2.",
              "x", "123?", "+=", "0-2147483647;", "65536*65536;", "46341*46341 ",
              "2147483647*2147483647!", "99999999999/0,", "2147483647/1:", "9/9:"};
    foreach (cases[i]) send_text(cases[i]);
    send_char(8'hFF);       // bad operator with the top bit set
    send_text("8/3");
    send_char(8'h80);       // terminator with the top bit set
    send_char(8'h00);
    wait_drained();
  endtask

  task automatic test_random_formulas(int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      send_formula();
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  task automatic test_noise(int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      case ($urandom_range(3))
        0: send_char(8'($urandom_range(255)));
        1: begin
          // digits then anything non-digit: often a bad operator
          send_operand();
          send_char(random_non_digit());
        end
        2: begin
          // formula cut short by a random byte in the second operand, unless it is a digit
          send_operand();
          send_char(random_operator());
          send_char(8'($urandom_range(255)));
        end
        default: send_formula();
      endcase
    end
  endtask

  task automatic test_back_to_back(int n_formulas);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    for (int i = 0; i < n_formulas; i++) send_formula();
    wait_drained();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 4; i++) begin
      send_formula();
      send_formula();
      wait_drained();
    end
  endtask

  // ---------------- sink, checker, watchdog ----------------

  always @(posedge clk) begin
    m_tready <= !sink_stalls || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = answer_t'({m_tdata, m_tuser});
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value=%0d left=%0d right=%0d op=%0d st=%0d wr=%0d",
                   $signed(got.value), got.left, got.right, got.op, got.status, got.wrapped);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch exp: value=%0d left=%0d right=%0d op=%0d st=%0d wr=%0d",
                     $signed(want.value), want.left, want.right, want.op, want.status,
                     want.wrapped);
            $display("         got: value=%0d left=%0d right=%0d op=%0d st=%0d wr=%0d",
                     $signed(got.value), got.left, got.right, got.op, got.status,
                     got.wrapped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_formulas(700);
    test_pause_until_drained();
    test_noise(250);
    test_back_to_back(20);
    test_random_formulas(150);
    wait_drained();
    repeat (2 * VALUE_WIDTH + 8) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
